// File: sv/r2fft_pkg.sv
// Shared types, constants and twiddle table for the radix-2 FFT block.
// No dependencies.
package r2fft_pkg;

    localparam int RES_W   = 23;
    localparam int TW_W    = 17;
    localparam int STORE_D = 64;
    localparam int ADDR_W  = 6;

    localparam logic [0:0] REG_INVERSE = 1'b0;
    localparam logic [0:0] REG_LOG2    = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BFLY_RD,
        ST_BFLY_MUL,
        ST_BFLY_WR,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } r2fft_state_t;

    typedef struct packed {
        logic              load_wr;
        logic              bfly_rd;
        logic              bfly_mul;
        logic              bfly_wr;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [4:0]        tw_idx;
        logic              scale;
    } r2fft_cmd_t;

    // Quarter-wave cosine table scaled to unsigned Q2.15, index 0..16
    function automatic logic [TW_W-1:0] qcos(input logic [4:0] p);
        logic [TW_W-1:0] r;
        unique case (p)
            5'd0:  r = 17'd32768;
            5'd1:  r = 17'd32610;
            5'd2:  r = 17'd32138;
            5'd3:  r = 17'd31357;
            5'd4:  r = 17'd30274;
            5'd5:  r = 17'd28899;
            5'd6:  r = 17'd27246;
            5'd7:  r = 17'd25330;
            5'd8:  r = 17'd23170;
            5'd9:  r = 17'd20788;
            5'd10: r = 17'd18205;
            5'd11: r = 17'd15447;
            5'd12: r = 17'd12540;
            5'd13: r = 17'd9512;
            5'd14: r = 17'd6393;
            5'd15: r = 17'd3212;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/radix2_complex_fft_top.sv
// Radix-2 DIT complex FFT, up to 64 points, in-place in a 23-bit work store.
// Load: one item per cycle. Butterflies: N/2*log2N of them, each read, multiplied
// and written in turn, limited by the shared complex multiplier and the store write port.
// The first point follows the last butterfly; each point is read from the store before
// it is shown, and the next one is not read until the current one is taken.
// Reset (async, rst_n low): forward mode, 64 points, load count zero; store not cleared.
module radix2_complex_fft_top
    import r2fft_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [2:0]                cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [2*SAMPLE_WIDTH-1:0] s_tdata,  // sample_re, sample_im
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,  // result_re, result_im, result_index
    output logic                      m_tlast
);

    logic       inverse_reg;
    logic [2:0] log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            log2_reg    <= 3'd6;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INVERSE: inverse_reg <= cfg_data[0];
                REG_LOG2:    log2_reg <= (cfg_data > 3'd6) ? 3'd6 : cfg_data;
                default: ;
            endcase
        end
    end

    logic clear;
    assign clear = cfg_we && (cfg_index == REG_LOG2);

    r2fft_cmd_t cmd;
    logic [ADDR_W-1:0] out_idx;
    logic signed [RES_W-1:0] out_re, out_im;

    r2fft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .m(log2_reg), .inverse(inverse_reg),
        .clear(clear), .in_fire(s_tvalid && s_tready),
        .out_fire(m_tvalid && m_tready), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_idx(out_idx), .out_last(m_tlast), .cmd(cmd)
    );

    r2fft_datapath #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
        .clk(clk), .cmd(cmd), .inverse(inverse_reg), .m(log2_reg),
        .in_re(s_tdata[SAMPLE_WIDTH-1:0]),
        .in_im(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .out_re(out_re), .out_im(out_im)
    );

    assign m_tdata = {4'd0, out_idx, out_im, out_re};

endmodule

// File: sv/r2fft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module r2fft_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/r2fft_datapath.sv
// Butterfly datapath: two mirrored stores, twiddle lookup, complex multiply, scaling.
// Depends on r2fft_pkg and r2fft_ram.
module r2fft_datapath
    import r2fft_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    clk,
    input  r2fft_cmd_t              cmd,
    input  logic                    inverse,
    input  logic [2:0]              m,
    input  logic [SAMPLE_WIDTH-1:0] in_re,
    input  logic [SAMPLE_WIDTH-1:0] in_im,
    output logic signed [RES_W-1:0] out_re,
    output logic signed [RES_W-1:0] out_im
);

    localparam int PW = RES_W + TW_W + 1;

    // Two read ports built as two copies written identically
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [2*RES_W-1:0] wdata, rd_a, rd_b;

    r2fft_ram #(.WIDTH(2*RES_W), .DEPTH(STORE_D)) u_ram_a (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(cmd.addr_a), .rdata(rd_a)
    );
    r2fft_ram #(.WIDTH(2*RES_W), .DEPTH(STORE_D)) u_ram_b (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(cmd.addr_b), .rdata(rd_b)
    );

    // Twiddle
    logic signed [TW_W:0] wr, wi, c, s;
    always_comb
    begin
        if (cmd.tw_idx <= 5'd16)
        begin
            c = signed'({1'b0, qcos(cmd.tw_idx)});
            s = signed'({1'b0, qcos(5'd16 - cmd.tw_idx)});
        end
        else
        begin
            c = -signed'({1'b0, qcos(5'd0 - cmd.tw_idx)});
            s = signed'({1'b0, qcos(cmd.tw_idx - 5'd16)});
        end
        wr = c;
        wi = inverse ? s : -s;
    end

    logic signed [TW_W:0] wr_reg, wi_reg;
    logic [ADDR_W-1:0] a_addr_reg, b_addr_reg, a2_reg, b2_reg;
    logic signed [RES_W-1:0] ar_reg, ai_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg;

    wire signed [RES_W-1:0] br = rd_b[RES_W-1:0];
    wire signed [RES_W-1:0] bi = rd_b[2*RES_W-1:RES_W];

    always_ff @(posedge clk)
    begin
        if (cmd.bfly_rd)
        begin
            wr_reg     <= wr;
            wi_reg     <= wi;
            a_addr_reg <= cmd.addr_a;
            b_addr_reg <= cmd.addr_b;
        end
        if (cmd.bfly_mul)
        begin
            prr_reg <= PW'(wr_reg * br);
            pii_reg <= PW'(wi_reg * bi);
            pri_reg <= PW'(wr_reg * bi);
            pir_reg <= PW'(wi_reg * br);
            ar_reg  <= rd_a[RES_W-1:0];
            ai_reg  <= rd_a[2*RES_W-1:RES_W];
            a2_reg  <= a_addr_reg;
            b2_reg  <= b_addr_reg;
        end
    end

    function automatic logic signed [RES_W-1:0] sat(input logic signed [RES_W+1:0] v);
        logic signed [RES_W+1:0] hi, lo;
        hi = (RES_W+2)'(2**(RES_W-1) - 1);
        lo = -(RES_W+2)'(2**(RES_W-1));
        if (v > hi) return hi[RES_W-1:0];
        if (v < lo) return lo[RES_W-1:0];
        return v[RES_W-1:0];
    endfunction

    logic signed [PW:0] sr, si;
    logic signed [RES_W+1:0] tr, ti;
    logic signed [RES_W-1:0] wr_a_re, wr_a_im, wr_b_re, wr_b_im;
    logic second_reg;
    always_comb
    begin
        sr = (PW+1)'(prr_reg) - (PW+1)'(pii_reg) + (PW+1)'(2**14);
        si = (PW+1)'(pri_reg) + (PW+1)'(pir_reg) + (PW+1)'(2**14);
        sr = sr >>> 15;
        si = si >>> 15;
        tr = (RES_W+2)'(sr);
        ti = (RES_W+2)'(si);
        wr_a_re = sat((RES_W+2)'(ar_reg) + tr);
        wr_a_im = sat((RES_W+2)'(ai_reg) + ti);
        wr_b_re = sat((RES_W+2)'(ar_reg) - tr);
        wr_b_im = sat((RES_W+2)'(ai_reg) - ti);
    end

    // Store write: load, or a butterfly write in two steps (a then b); the upper
    // address goes last so the next stage's first read never meets it
    logic signed [RES_W-1:0] b_new_re_reg, b_new_im_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.bfly_wr)
        begin
            b_new_re_reg <= wr_b_re;
            b_new_im_reg <= wr_b_im;
        end
        second_reg <= cmd.bfly_wr;
    end

    always_comb
    begin
        we    = cmd.load_wr | cmd.bfly_wr | second_reg;
        waddr = cmd.addr_a;
        wdata = {2*RES_W{1'b0}};
        if (cmd.load_wr)
        begin
            wdata = {RES_W'(signed'(in_im)), RES_W'(signed'(in_re))};
        end
        else if (cmd.bfly_wr)
        begin
            waddr = a2_reg;
            wdata = {wr_a_im, wr_a_re};
        end
        else if (second_reg)
        begin
            waddr = b2_reg;
            wdata = {b_new_im_reg, b_new_re_reg};
        end
    end

    // Output with optional rounded divide by N
    logic signed [RES_W:0] xr, xi, rr, ri;
    always_comb
    begin
        xr = (RES_W+1)'(signed'(rd_a[RES_W-1:0]));
        xi = (RES_W+1)'(signed'(rd_a[2*RES_W-1:RES_W]));
        if (cmd.scale && m != 3'd0)
        begin
            rr = (xr + ((RES_W+1)'(1) <<< (m - 3'd1))) >>> m;
            ri = (xi + ((RES_W+1)'(1) <<< (m - 3'd1))) >>> m;
        end
        else
        begin
            rr = xr;
            ri = xi;
        end
        out_re = rr[RES_W-1:0];
        out_im = ri[RES_W-1:0];
    end

endmodule

// File: sv/r2fft_ctrl.sv
// Sequencer for load, butterfly stages and output of the radix-2 FFT.
// Depends on r2fft_pkg.
module r2fft_ctrl
    import r2fft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        m,
    input  logic              inverse,
    input  logic              clear,
    input  logic              in_fire,
    input  logic              out_fire,
    output logic              in_ready,
    output logic              out_valid,
    output logic [ADDR_W-1:0] out_idx,
    output logic              out_last,
    output r2fft_cmd_t        cmd
);

    r2fft_state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;       // load count / output index
    logic [2:0] stage_reg, stage_next;
    logic [4:0] bf_reg, bf_next;          // butterfly within stage

    logic [6:0] n;
    assign n = 7'd1 << m;

    function automatic logic [5:0] brev(input logic [5:0] v, input logic [2:0] bits);
        logic [5:0] r;
        r = '0;
        for (int b = 0; b < 6; b++)
        begin
            if (3'(b) < bits) r[bits - 3'(b) - 3'd1] = v[b];
        end
        return r;
    endfunction

    // Butterfly addressing: j = bf mod half, group = bf / half
    logic [5:0] half, jj, grp, ia;
    always_comb
    begin
        half = 6'd1 << stage_reg;
        jj   = 6'(bf_reg) & (half - 6'd1);
        grp  = 6'(bf_reg) >> stage_reg;
        ia   = ((grp << stage_reg) << 1) | jj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            stage_reg <= '0;
            bf_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stage_reg <= stage_next;
            bf_reg    <= bf_next;
        end
    end

    logic last_bf;
    assign last_bf = (6'(bf_reg) == 6'(n >> 1) - 6'd1) || (m == 3'd0);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        bf_next    = bf_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        cmd.scale  = inverse;
        cmd.tw_idx = 5'(jj << (3'd5 - stage_reg));
        cmd.addr_a = ia;
        cmd.addr_b = ia | half;
        out_idx    = cnt_reg[5:0];
        out_last   = (cnt_reg == n - 7'd1);
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready    = 1'b1;
                cmd.addr_a  = brev(cnt_reg[5:0], m);
                cmd.load_wr = in_fire;
                if (in_fire)
                begin
                    if (cnt_reg + 7'd1 >= n)
                    begin
                        cnt_next   = '0;
                        stage_next = '0;
                        bf_next    = '0;
                        state_next = (m == 3'd0) ? ST_OUT_RD : ST_BFLY_RD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            ST_BFLY_RD:
            begin
                cmd.bfly_rd = 1'b1;
                state_next  = ST_BFLY_MUL;
            end
            ST_BFLY_MUL:
            begin
                cmd.bfly_mul = 1'b1;
                state_next   = ST_BFLY_WR;
            end
            ST_BFLY_WR:
            begin
                cmd.bfly_wr = 1'b1;
                if (last_bf)
                begin
                    bf_next = '0;
                    if (stage_reg == m - 3'd1)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        stage_next = stage_reg + 3'd1;
                        state_next = ST_BFLY_RD;
                    end
                end
                else
                begin
                    bf_next    = bf_reg + 5'd1;
                    state_next = ST_BFLY_RD;
                end
            end
            ST_OUT_RD:
            begin
                // the read is issued again in ST_OUT_WAIT so the second store write lands first
                cmd.addr_a = cnt_reg[5:0];
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                cmd.addr_a = cnt_reg[5:0];
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
            begin
                cmd.addr_a = cnt_reg[5:0];
                out_valid  = 1'b1;
                if (out_fire)
                begin
                    if (out_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 7'd1;
                        cmd.addr_a = cnt_next[5:0];
                        state_next = ST_OUT_WAIT;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
        if (clear)
        begin
            cnt_next   = '0;
            state_next = ST_LOAD;
        end
    end

endmodule
